>>> rtl/sfd_pkg.sv
// Shared types and constants for the stereo feedback delay.
// Holds widths, the controller state and command types, and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam int LINE_DEPTH = 65536;
    localparam int SAMPLE_W   = 16;

    localparam int NUM_CH    = 2;
    localparam int IO_W      = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int GAIN_W    = 15;
    localparam int TONE_W    = 24;
    localparam int Q_ONE     = 32768;
    localparam int ROUND15   = 2 ** 14;
    localparam int ROUND23   = 2 ** 22;

    localparam int ADDR_W    = $clog2(LINE_DEPTH);
    localparam int DLY_W     = (ADDR_W > CFG_W) ? ADDR_W : CFG_W;
    localparam int MAX_DELAY = LINE_DEPTH - 1;

    // Lowpass: c * (d*256 - s)
    localparam int DIFF_W  = ((SAMPLE_W + 8 > TONE_W) ? SAMPLE_W + 8 : TONE_W) + 1;
    localparam int TPROD_W = DIFF_W + 17;
    localparam int TSUM_W  = TPROD_W - 14;

    // Feedback: s * gain / 2^23
    localparam int FBPROD_W = TONE_W + GAIN_W + 1;
    localparam int FB_W     = FBPROD_W - 23;
    localparam int WSUM_W   = (FB_W + 1 > SAMPLE_W + 1) ? FB_W + 1 : SAMPLE_W + 1;

    // Dry/wet mix accumulator
    localparam int MACC_W = ((IO_W + 18 > SAMPLE_W + 18) ? IO_W + 18 : SAMPLE_W + 18) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY     = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_MIX       = 3'd2,
        CFG_TONE      = 3'd3,
        CFG_PING_PONG = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TONE,
        ST_WRITE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic accept;      // capture frame, issue line read
        logic tone;        // update lowpass states, form mix
        logic line_write;  // write feedback sum, advance write position
        logic out_load;    // move mix into the output register
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/sfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/sfd_ctrl.sv
// Sequencing controller: handshakes and per-frame command steps.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_ctrl (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output sfd_pkg::t_cmd o_cmd
);
    import sfd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // Output slot is free if empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_TONE;
                end
            end
            ST_TONE: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:  o_cmd.accept     = i_in_valid;
            ST_TONE:  o_cmd.tone       = 1'b1;
            ST_WRITE: begin
                o_cmd.line_write = 1'b1;
                o_cmd.out_load   = out_free;
            end
            ST_HOLD:  o_cmd.out_load   = out_free;
            default:  o_cmd            = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/sfd_datapath.sv
// Datapath: config registers, delay lines, lowpass states, feedback and mix.
// Depends on sfd_pkg and sfd_ram.
`timescale 1ns / 1ps
`default_nettype none

module sfd_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sfd_pkg::t_cmd                   i_cmd,
    input  wire logic                            i_cfg_we,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sfd_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic signed [sfd_pkg::IO_W-1:0] i_in_left,
    input  wire logic signed [sfd_pkg::IO_W-1:0] i_in_right,
    output logic signed [sfd_pkg::IO_W-1:0]      o_out_left,
    output logic signed [sfd_pkg::IO_W-1:0]      o_out_right
);
    import sfd_pkg::*;

    // Configuration
    logic [CFG_W-1:0]  r_delay;
    logic [GAIN_W-1:0] r_gain;
    logic [CFG_W-1:0]  r_mix_lvl;
    logic [CFG_W-1:0]  r_tone_c;
    logic              r_ping;

    // Per-frame state
    logic signed [IO_W-1:0]   r_in   [NUM_CH];
    logic signed [TONE_W-1:0] r_tone [NUM_CH];
    logic signed [IO_W-1:0]   r_mix  [NUM_CH];
    logic signed [IO_W-1:0]   r_out  [NUM_CH];
    logic [ADDR_W-1:0]        r_wp;
    logic                     r_wrapped;
    logic                     r_rd_ok;

    // Read address
    logic [DLY_W-1:0]  dly_ext;
    logic [DLY_W-1:0]  dly_c;
    logic [ADDR_W-1:0] dly_a;
    logic [ADDR_W:0]   wrap_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;

    // Lane arithmetic
    logic [SAMPLE_W-1:0]        ram_q   [NUM_CH];
    logic signed [SAMPLE_W-1:0] d_eff   [NUM_CH];
    logic signed [DIFF_W-1:0]   diff    [NUM_CH];
    logic signed [TPROD_W-1:0]  tprod   [NUM_CH];
    logic signed [TPROD_W-1:0]  tshift  [NUM_CH];
    logic signed [TSUM_W-1:0]   tsum    [NUM_CH];
    logic signed [TONE_W-1:0]   tone_n  [NUM_CH];
    logic signed [MACC_W-1:0]   macc    [NUM_CH];
    logic signed [MACC_W-1:0]   msh     [NUM_CH];
    logic signed [IO_W-1:0]     mix_n   [NUM_CH];
    logic signed [FBPROD_W-1:0] fprod   [NUM_CH];
    logic signed [FBPROD_W-1:0] fsh     [NUM_CH];
    logic signed [FB_W-1:0]     fb      [NUM_CH];
    logic signed [WSUM_W-1:0]   wsum    [NUM_CH];
    logic [SAMPLE_W-1:0]        w_sat   [NUM_CH];

    logic [CFG_W-1:0]    tc;
    logic [CFG_W-1:0]    mx;
    logic signed [16:0]  coef_s;
    logic signed [17:0]  mx_s;
    logic signed [17:0]  omm_s;
    logic signed [GAIN_W:0] gain_s;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= CFG_W'(12000);
            r_gain    <= GAIN_W'(11469);
            r_mix_lvl <= CFG_W'(9830);
            r_tone_c  <= CFG_W'(17826);
            r_ping    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY:     r_delay   <= i_cfg_data;
                CFG_GAIN:      r_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_MIX:       r_mix_lvl <= i_cfg_data;
                CFG_TONE:      r_tone_c  <= i_cfg_data;
                CFG_PING_PONG: r_ping    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp delay to 1 .. depth-1, read that far behind the write position
    always_comb begin
        dly_ext = DLY_W'(r_delay);
        if (dly_ext == '0) begin
            dly_c = DLY_W'(1);
        end else if (dly_ext > DLY_W'(MAX_DELAY)) begin
            dly_c = DLY_W'(MAX_DELAY);
        end else begin
            dly_c = dly_ext;
        end
        dly_a    = dly_c[ADDR_W-1:0];
        wrap_sum = {1'b0, r_wp} + (ADDR_W + 1)'(LINE_DEPTH) - {1'b0, dly_a};
        if (r_wp >= dly_a) begin
            rd_addr = r_wp - dly_a;
        end else begin
            rd_addr = wrap_sum[ADDR_W-1:0];
        end
        // Lines fill in write order: before the first wrap only entries below wp exist
        rd_ok = r_wrapped || (rd_addr < r_wp);
    end

    always_comb begin
        tc     = (r_tone_c > CFG_W'(Q_ONE)) ? CFG_W'(Q_ONE) : r_tone_c;
        mx     = (r_mix_lvl > CFG_W'(Q_ONE)) ? CFG_W'(Q_ONE) : r_mix_lvl;
        coef_s = $signed({1'b0, tc});
        mx_s   = $signed({2'b00, mx});
        omm_s  = $signed({1'b0, 17'(Q_ONE) - {1'b0, mx}});
        gain_s = $signed({1'b0, r_gain});
    end

    // Lowpass update and mix, used in the tone step
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            d_eff[k]  = r_rd_ok ? $signed(ram_q[k]) : '0;
            diff[k]   = (DIFF_W'(d_eff[k]) <<< 8) - DIFF_W'(r_tone[k]);
            tprod[k]  = diff[k] * coef_s;
            tshift[k] = (tprod[k] + TPROD_W'(ROUND15)) >>> 15;
            tsum[k]   = TSUM_W'(tshift[k]) + TSUM_W'(r_tone[k]);
            if (&tsum[k][TSUM_W-1:TONE_W-1] || ~|tsum[k][TSUM_W-1:TONE_W-1]) begin
                tone_n[k] = tsum[k][TONE_W-1:0];
            end else if (tsum[k][TSUM_W-1]) begin
                tone_n[k] = {1'b1, {(TONE_W-1){1'b0}}};
            end else begin
                tone_n[k] = {1'b0, {(TONE_W-1){1'b1}}};
            end

            macc[k] = MACC_W'(r_in[k]) * MACC_W'(omm_s)
                      + MACC_W'(d_eff[k]) * MACC_W'(mx_s)
                      + MACC_W'(ROUND15);
            msh[k]  = macc[k] >>> 15;
            if (&msh[k][MACC_W-1:IO_W-1] || ~|msh[k][MACC_W-1:IO_W-1]) begin
                mix_n[k] = msh[k][IO_W-1:0];
            end else if (msh[k][MACC_W-1]) begin
                mix_n[k] = {1'b1, {(IO_W-1){1'b0}}};
            end else begin
                mix_n[k] = {1'b0, {(IO_W-1){1'b1}}};
            end
        end
    end

    // Feedback scaling and line write value, used in the write step
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            fprod[k] = r_tone[k] * gain_s;
            fsh[k]   = (fprod[k] + FBPROD_W'(ROUND23)) >>> 23;
            fb[k]    = fsh[k][FB_W-1:0];
        end
        for (int k = 0; k < NUM_CH; k++) begin
            if (r_ping) begin
                wsum[k] = WSUM_W'(r_in[k]) + WSUM_W'(fb[NUM_CH-1-k]);
            end else begin
                wsum[k] = WSUM_W'(r_in[k]) + WSUM_W'(fb[k]);
            end
            if (&wsum[k][WSUM_W-1:SAMPLE_W-1] || ~|wsum[k][WSUM_W-1:SAMPLE_W-1]) begin
                w_sat[k] = wsum[k][SAMPLE_W-1:0];
            end else if (wsum[k][WSUM_W-1]) begin
                w_sat[k] = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end else begin
                w_sat[k] = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
        end
    end

    // Control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_rd_ok   <= 1'b0;
            for (int k = 0; k < NUM_CH; k++) begin
                r_tone[k] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_rd_ok <= rd_ok;
            end
            if (i_cmd.tone) begin
                for (int k = 0; k < NUM_CH; k++) begin
                    r_tone[k] <= tone_n[k];
                end
            end
            if (i_cmd.line_write) begin
                if (r_wp == ADDR_W'(LINE_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + ADDR_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in[0] <= i_in_left;
            r_in[1] <= i_in_right;
        end
        for (int k = 0; k < NUM_CH; k++) begin
            if (i_cmd.tone) begin
                r_mix[k] <= mix_n[k];
            end
            if (i_cmd.out_load) begin
                r_out[k] <= r_mix[k];
            end
        end
    end

    sfd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_left (
        .i_clk   (i_clk),
        .i_we    (i_cmd.line_write),
        .i_waddr (r_wp),
        .i_wdata (w_sat[0]),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q[0])
    );

    sfd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_right (
        .i_clk   (i_clk),
        .i_we    (i_cmd.line_write),
        .i_waddr (r_wp),
        .i_wdata (w_sat[1]),
        .i_re    (i_cmd.accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q[1])
    );

    assign o_out_left  = r_out[0];
    assign o_out_right = r_out[1];

endmodule

`default_nettype wire

>>> rtl/stereo_feedback_delay.sv
// Top level of the stereo ping-pong feedback delay.
// Depends on sfd_pkg, sfd_ctrl and sfd_datapath (which holds the sfd_ram lines).
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------------
//   input    | in        | i_in_valid / o_in_ready    | i_in_left, i_in_right
//   output   | out       | o_out_valid / i_out_ready  | o_out_left, o_out_right
//   config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// A frame passes through three steps: transfer and line read, lowpass and mix,
// feedback write. The registered read of the delay-line RAM and the two multiply
// steps (lowpass, then feedback gain) set these steps.
// A finished frame waits in the output register; a new frame is taken meanwhile,
// and after its write step the sequencer holds until the output register is free.
// Reset is synchronous; the lines are not swept. A fill mark (write position
// plus wrapped flag) makes unwritten entries read as zero, so the block is
// ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_delay (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input frame
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic signed [sfd_pkg::IO_W-1:0] i_in_left,
    input  wire logic signed [sfd_pkg::IO_W-1:0] i_in_right,
    // Output frame
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [sfd_pkg::IO_W-1:0]      o_out_left,
    output logic signed [sfd_pkg::IO_W-1:0]      o_out_right,
    // Register writes
    input  wire logic                            i_cfg_we,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sfd_pkg::CFG_W-1:0]       i_cfg_data
);
    import sfd_pkg::*;

    // Step commands from the sequencer to the datapath
    t_cmd cmd;

    // Sequencer: advance one frame through its steps, hold the output handshake
    sfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Datapath: registers, delay lines, lowpass, feedback and mix arithmetic
    sfd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_left   (i_in_left),
        .i_in_right  (i_in_right),
        .o_out_left  (o_out_left),
        .o_out_right (o_out_right)
    );

endmodule

`default_nettype wire

>>> rtl/sfd_checker.sv
// Port-level checks for the stereo feedback delay, bound to the top level.
// Depends on sfd_pkg and stereo_feedback_delay.
`timescale 1ns / 1ps
`default_nettype none

module sfd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic signed [sfd_pkg::IO_W-1:0] i_in_left,
    input wire logic signed [sfd_pkg::IO_W-1:0] i_in_right,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic signed [sfd_pkg::IO_W-1:0] o_out_left,
    input wire logic signed [sfd_pkg::IO_W-1:0] o_out_right,
    input wire logic                            i_cfg_we,
    input wire logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input wire logic [sfd_pkg::CFG_W-1:0]       i_cfg_data
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_left) && $stable(o_out_right))
        else $error("output changed while stalled");

    // One frame at a time: no new transfer during the two work steps
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken while a frame is in work");

    // A result appears only at the end of a frame's work
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without frame in work");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (.*);

`default_nettype wire
